>>> design/periodic_coordinate_wrap_defines.svh
// Assertion helpers for the coordinate wrap block.
`ifndef PERIODIC_COORDINATE_WRAP_DEFINES_SVH
`define PERIODIC_COORDINATE_WRAP_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define PCW_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define PCW_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> design/pcw_pkg.sv
`timescale 1ns / 1ps
package pcw_pkg;
  localparam int unsigned NumRegs = 8;
  localparam logic [2:0] RegOriginZMode = 3'd7;
  localparam logic [1:0] StatDone = 2'd0;
  localparam logic [1:0] StatPass = 2'd1;
  localparam logic [1:0] StatNoImg = 2'd2;
  localparam logic [1:0] StatBadKind = 2'd3;
  localparam logic [1:0] KindCart = 2'd0;
  localparam logic [1:0] KindScaled = 2'd1;

  // Per-item control traveling down the pipe.
  typedef struct packed {
    logic       convert;   // result comes from to_cart
    logic       use_frac;  // Cartesian input needs to_frac
    logic       do_wrap;   // take floor, keep fraction
    logic       add_img;   // unwrap: add image counts
    logic       set_img;   // wrap: update image counts
    logic       acc_img;   // wrap: accumulate onto input counts
    logic [1:0] status;
  } ctrl_t;

  typedef struct packed {
    logic signed [31:0] lx, ly, lz, yz, xz, xy;
    logic signed [31:0] i0, i1, i2, i3, i4, i5;
    logic signed [31:0] ox, oy, oz;
  } box_t;

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) return 16'sh7fff;
    if (v < -48'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
    if (v > 96'sd2147483647) return 32'sh7fffffff;
    if (v < -96'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

>>> design/pcw_cart.sv
`timescale 1ns / 1ps
// Fractional (30 fraction bits) to Cartesian, two register stages.
module pcw_cart (
  input  logic                clk_i,
  input  logic                en_i,
  input  pcw_pkg::box_t       box_i,
  input  logic signed [51:0]  l_i [3],
  output logic signed [31:0]  c_o [3]
);
  import pcw_pkg::*;
  logic signed [21:0] hi [3];
  logic signed [31:0] lo [3];
  logic signed [63:0] ph_q [6];
  logic signed [63:0] pl_q [6];
  logic signed [95:0] sum_q [3];
  logic signed [63:0] lsum [3];
  logic signed [95:0] hsum [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hi[k] = l_i[k][51:30];
      lo[k] = {2'b00, l_i[k][29:0]};
    end
  end

  // Stage 1: products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q[0] <= 64'(box_i.lx * hi[0]);
      ph_q[1] <= 64'(box_i.xy * hi[1]);
      ph_q[2] <= 64'(box_i.xz * hi[2]);
      ph_q[3] <= 64'(box_i.ly * hi[1]);
      ph_q[4] <= 64'(box_i.yz * hi[2]);
      ph_q[5] <= 64'(box_i.lz * hi[2]);
      pl_q[0] <= 64'(box_i.lx * lo[0]);
      pl_q[1] <= 64'(box_i.xy * lo[1]);
      pl_q[2] <= 64'(box_i.xz * lo[2]);
      pl_q[3] <= 64'(box_i.ly * lo[1]);
      pl_q[4] <= 64'(box_i.yz * lo[2]);
      pl_q[5] <= 64'(box_i.lz * lo[2]);
    end
  end

  always_comb begin
    lsum[0] = pl_q[0] + pl_q[1] + pl_q[2];
    lsum[1] = pl_q[3] + pl_q[4];
    lsum[2] = pl_q[5];
    hsum[0] = 96'(ph_q[0]) + 96'(ph_q[1]) + 96'(ph_q[2]) + 96'(box_i.ox);
    hsum[1] = 96'(ph_q[3]) + 96'(ph_q[4]) + 96'(box_i.oy);
    hsum[2] = 96'(ph_q[5]) + 96'(box_i.oz);
  end

  // Stage 2: sums.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) sum_q[k] <= hsum[k] + 96'(lsum[k] >>> 30);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) c_o[k] = sat32(sum_q[k]);
  end
endmodule

>>> design/periodic_coordinate_wrap.sv
`timescale 1ns / 1ps
// Channel   | dir | tdata fields (low bit up)                      | tuser
// s_axis    | in  | pos_x, pos_y, pos_z, image_x, image_y, image_z  | -
// m_axis    | out | new_x, new_y, new_z, new_image_x/y/z, status    | -
// cfg       | in  | cfg_addr_i (register index), cfg_data_i          | -
//
// One transaction per cycle while m_axis is not stalled; five register stages:
// to_frac products, to_frac sums, floor/image update, to_cart products and
// to_cart sums.
// Reset clears the configuration registers and the pipe valid bits.
// A stall at m_axis freezes the whole pipe; s_axis_tready drops whenever
// the output holds a transaction that is not taken in that cycle.
module periodic_coordinate_wrap (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,  // pos_x, pos_y, pos_z, image_x, image_y, image_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [151:0] m_axis_tdata,  // new_x/y/z, new_image_x/y/z, status, 6 zero bits
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_addr_i,
  input  logic [63:0]  cfg_data_i
);
  import pcw_pkg::*;
  `include "periodic_coordinate_wrap_defines.svh"

  logic [63:0] reg_q [NumRegs];
  box_t box;
  logic unwrap, images;
  logic [1:0] scaled, wrapped;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) reg_q[i] <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_addr_i == RegOriginZMode) reg_q[cfg_addr_i] <= {26'd0, cfg_data_i[37:0]};
      else reg_q[cfg_addr_i] <= cfg_data_i;
    end
  end

  always_comb begin
    box.lx = reg_q[0][31:0]; box.ly = reg_q[0][63:32];
    box.lz = reg_q[1][31:0]; box.yz = reg_q[1][63:32];
    box.xz = reg_q[2][31:0]; box.xy = reg_q[2][63:32];
    box.i0 = reg_q[3][31:0]; box.i1 = reg_q[3][63:32];
    box.i2 = reg_q[4][31:0]; box.i3 = reg_q[4][63:32];
    box.i4 = reg_q[5][31:0]; box.i5 = reg_q[5][63:32];
    box.ox = reg_q[6][31:0]; box.oy = reg_q[6][63:32];
    box.oz = reg_q[7][31:0];
    unwrap  = reg_q[7][32];
    scaled  = reg_q[7][34:33];
    wrapped = reg_q[7][36:35];
    images  = reg_q[7][37];
  end

  // Pipe control: whole-pipe enable, output stage is last.
  localparam int Depth = 5;
  logic [Depth-1:0] vld_q;
  logic en;
  assign en = !vld_q[Depth-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Depth-1];
  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Depth-2:0], in_fire};
  end

  // Decode.
  ctrl_t ctl;
  always_comb begin
    ctl = '0;
    if (scaled != KindCart && scaled != KindScaled) begin
      ctl.status = unwrap ? StatBadKind : StatPass;
    end else if (!unwrap) begin
      ctl.convert = 1'b1; ctl.do_wrap = 1'b1;
      ctl.use_frac = (scaled == KindCart);
      ctl.set_img = images; ctl.acc_img = (wrapped != 2'd0);
      ctl.status = StatDone;
    end else if (wrapped == 2'd0) begin
      ctl.convert = (scaled == KindScaled);
      ctl.status = (scaled == KindScaled) ? StatDone : StatPass;
    end else if (!images) begin
      ctl.status = StatNoImg;
    end else begin
      ctl.convert = 1'b1; ctl.add_img = 1'b1;
      ctl.use_frac = (scaled == KindCart);
      ctl.status = StatDone;
    end
  end

  logic signed [31:0] p [3];
  logic signed [15:0] img [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p[k] = s_axis_tdata[32*k +: 32];
      img[k] = s_axis_tdata[96+16*k +: 16];
    end
  end

  // Stage 1: to_frac products, split of (p - origin) at bit 16 into a 17-bit hi and a 16-bit lo part.
  logic signed [32:0] d [3];
  logic signed [16:0] dh [3];
  logic signed [16:0] dl [3];
  always_comb begin
    d[0] = 33'(p[0]) - 33'(box.ox);
    d[1] = 33'(p[1]) - 33'(box.oy);
    d[2] = 33'(p[2]) - 33'(box.oz);
    for (int k = 0; k < 3; k++) begin
      dh[k] = 17'(d[k] >>> 16);
      dl[k] = {1'b0, d[k][15:0]};
    end
  end

  ctrl_t c1_q, c2_q, c3_q, c4_q, c5_q;
  logic signed [31:0] p1_q [3], p2_q [3], p3_q [3], p4_q [3], p5_q [3];
  logic signed [15:0] g1_q [3], g2_q [3], g3_q [3], g4_q [3], g5_q [3];
  logic signed [49:0] fh_q [6];
  logic signed [49:0] fl_q [6];

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q <= ctl; p1_q <= p; g1_q <= img;
      fh_q[0] <= 50'(dh[0] * box.i0);
      fh_q[1] <= 50'(dh[1] * box.i5);
      fh_q[2] <= 50'(dh[2] * box.i4);
      fh_q[3] <= 50'(dh[1] * box.i1);
      fh_q[4] <= 50'(dh[2] * box.i3);
      fh_q[5] <= 50'(dh[2] * box.i2);
      fl_q[0] <= 50'(dl[0] * box.i0);
      fl_q[1] <= 50'(dl[1] * box.i5);
      fl_q[2] <= 50'(dl[2] * box.i4);
      fl_q[3] <= 50'(dl[1] * box.i1);
      fl_q[4] <= 50'(dl[2] * box.i3);
      fl_q[5] <= 50'(dl[2] * box.i2);
    end
  end

  // Stage 2: fractional coordinates, 30 fraction bits.
  logic signed [51:0] fs [3];
  logic signed [51:0] l2_q [3];
  always_comb begin
    fs[0] = 52'(fh_q[0]) + 52'(fh_q[1]) + 52'(fh_q[2])
          + ((52'(fl_q[0]) + 52'(fl_q[1]) + 52'(fl_q[2])) >>> 16);
    fs[1] = 52'(fh_q[3]) + 52'(fh_q[4]) + ((52'(fl_q[3]) + 52'(fl_q[4])) >>> 16);
    fs[2] = 52'(fh_q[5]) + (52'(fl_q[5]) >>> 16);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_q <= c1_q; p2_q <= p1_q; g2_q <= g1_q;
      for (int k = 0; k < 3; k++)
        l2_q[k] <= c1_q.use_frac ? fs[k] : 52'(52'(p1_q[k]) <<< 14);
    end
  end

  // Stage 3: floor / image handling.
  logic signed [51:0] l3 [3];
  logic signed [21:0] fl3 [3];
  logic signed [15:0] g3 [3];
  logic signed [51:0] l3_q [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fl3[k] = 22'(l2_q[k] >>> 30);
      l3[k] = l2_q[k];
      g3[k] = g2_q[k];
      if (c2_q.do_wrap) begin
        l3[k] = {22'd0, l2_q[k][29:0]};
        if (c2_q.set_img)
          g3[k] = sat16(c2_q.acc_img ? 48'(g2_q[k]) + 48'(fl3[k]) : 48'(fl3[k]));
      end else if (c2_q.add_img) begin
        l3[k] = l2_q[k] + (52'(g2_q[k]) <<< 30);
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      c3_q <= c2_q; p3_q <= p2_q; g3_q <= g3; l3_q <= l3;
    end
  end

  // Stages 4 and 5: to_cart.
  logic signed [31:0] cart [3];
  pcw_cart u_cart (
    .clk_i (clk_i), .en_i (en), .box_i (box), .l_i (l3_q), .c_o (cart)
  );
  always_ff @(posedge clk_i) begin
    if (en) begin
      c4_q <= c3_q; p4_q <= p3_q; g4_q <= g3_q;
      c5_q <= c4_q; p5_q <= p4_q; g5_q <= g4_q;
    end
  end

  logic signed [31:0] outp [3];
  always_comb begin
    for (int k = 0; k < 3; k++) outp[k] = c5_q.convert ? cart[k] : p5_q[k];
  end
  assign m_axis_tdata = {6'd0, c5_q.status, g5_q[2], g5_q[1], g5_q[0],
                         outp[2], outp[1], outp[0]};

  // Checks.
  `PCW_ASSERT_IMP(a_out_hold, m_axis_tvalid && !m_axis_tready, !s_axis_tready || !vld_q[Depth-1])
  `PCW_ASSERT_NXT(a_stall_keeps, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `PCW_ASSERT_IMP(a_conv_ok, m_axis_tvalid && c5_q.convert, c5_q.status == StatDone)
endmodule
